// ===== design/lacb_pkg.sv =====
package lacb_pkg;

    // Block-scaled vectors keep their largest magnitude in [2^(TOP_BITS-1), 2^TOP_BITS).
    localparam int TOP_BITS = 30;
    localparam int SCL_W    = TOP_BITS + 1;
    localparam int CRS_W    = 2 * TOP_BITS + 2;

    typedef logic signed [SCL_W-1:0] scl_t;
    typedef logic signed [CRS_W-1:0] crs_t;
    typedef logic signed [31:0]      comp_t;

    // Matrix row codes, in output order.
    typedef enum logic [1:0] {
        ROW_RIGHT = 2'd0,
        ROW_UP    = 2'd1,
        ROW_FWD   = 2'd2,
        ROW_EYE   = 2'd3
    } row_t;

endpackage

// ===== design/lacb_blk.sv =====
module lacb_blk #(
    parameter int IN_W = 32
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [IN_W-1:0] vec_in [3],
    output lacb_pkg::scl_t         vec_out [3]
);
    import lacb_pkg::*;

    localparam int LW = $clog2(IN_W);

    logic [IN_W-1:0] mag_reg [3];
    logic [2:0]      neg_reg;
    logic [IN_W-1:0] mag2_reg [3];
    logic [2:0]      neg2_reg;
    logic            shr_reg;
    logic [LW-1:0]   amt_reg;
    scl_t            vec_reg [3];

    logic [IN_W-1:0] max_mag;
    logic [LW-1:0]   lead;
    logic            shr_next;
    logic [LW-1:0]   amt_next;
    logic [IN_W-1:0] shifted [3];

    // Largest magnitude and the position of its leading one.
    always_comb
    begin
        max_mag = mag_reg[0];
        if (mag_reg[1] > max_mag)
        begin
            max_mag = mag_reg[1];
        end
        if (mag_reg[2] > max_mag)
        begin
            max_mag = mag_reg[2];
        end
        lead = '0;
        for (int i = 0; i < IN_W; i++)
        begin
            if (max_mag[i])
            begin
                lead = LW'(i);
            end
        end
        shr_next = (int'(lead) >= TOP_BITS);
        amt_next = shr_next ? LW'(int'(lead) - (TOP_BITS - 1))
                            : LW'((TOP_BITS - 1) - int'(lead));
    end

    // Shift every magnitude by the common amount.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            shifted[i] = shr_reg ? (mag2_reg[i] >> amt_reg) : (mag2_reg[i] << amt_reg);
        end
    end

    // Three stages: magnitudes, shift search, shift and sign.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i]  <= vec_in[i][IN_W-1] ? IN_W'(-vec_in[i]) : IN_W'(vec_in[i]);
                neg_reg[i]  <= vec_in[i][IN_W-1];
                mag2_reg[i] <= mag_reg[i];
                neg2_reg[i] <= neg_reg[i];
                vec_reg[i]  <= neg2_reg[i] ? -$signed({1'b0, shifted[i][TOP_BITS-1:0]})
                                           :  $signed({1'b0, shifted[i][TOP_BITS-1:0]});
            end
            shr_reg <= shr_next;
            amt_reg <= amt_next;
        end
    end

    assign vec_out = vec_reg;

endmodule

// ===== design/lacb_cross.sv =====
module lacb_cross (
    input  logic           clk,
    input  logic           en,
    input  lacb_pkg::scl_t a [3],
    input  lacb_pkg::scl_t b [3],
    output lacb_pkg::crs_t prod [3]
);
    import lacb_pkg::*;

    crs_t p_reg [6];
    crs_t prod_reg [3];

    // Products first, differences one stage later.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= a[1] * b[2];
            p_reg[1] <= a[2] * b[1];
            p_reg[2] <= a[2] * b[0];
            p_reg[3] <= a[0] * b[2];
            p_reg[4] <= a[0] * b[1];
            p_reg[5] <= a[1] * b[0];
            prod_reg[0] <= p_reg[0] - p_reg[1];
            prod_reg[1] <= p_reg[2] - p_reg[3];
            prod_reg[2] <= p_reg[4] - p_reg[5];
        end
    end

    assign prod = prod_reg;

endmodule

// ===== design/lacb_unit.sv =====
module lacb_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            en,
    input  lacb_pkg::scl_t  vec_in [3],
    output lacb_pkg::comp_t comp [3],
    output logic            zero
);
    import lacb_pkg::*;

    localparam int MAG_W  = TOP_BITS;
    localparam int SUM_W  = 2 * TOP_BITS + 2;
    localparam int RT_W   = TOP_BITS + 1;
    localparam int REM_W  = RT_W + 4;
    localparam int SQ_STG = RT_W;
    localparam int QW     = FRAC_BITS + 1;
    localparam int NW     = TOP_BITS + FRAC_BITS + 1;

    logic [MAG_W-1:0]   mag1_reg [3];
    logic [2:0]         neg1_reg;
    logic [2*MAG_W-1:0] sq_reg [3];
    logic [MAG_W-1:0]   mag2_reg [3];
    logic [2:0]         neg2_reg;
    logic               zero2_reg;

    // Square root pipeline, index 0 holds the sum of squares.
    logic [SUM_W-1:0]   sn_reg   [SQ_STG+1];
    logic [REM_W-1:0]   srem_reg [SQ_STG+1];
    logic [RT_W-1:0]    root_reg [SQ_STG+1];
    logic [MAG_W-1:0]   smag_reg [SQ_STG+1][3];
    logic [2:0]         sneg_reg [SQ_STG+1];
    logic               szero_reg [SQ_STG+1];

    // Divider pipeline, index 0 holds the rounded numerators.
    logic [MAG_W:0]     dr_reg   [QW+1][3];
    logic [QW-1:0]      nlow_reg [QW+1][3];
    logic [QW-1:0]      q_reg    [QW+1][3];
    logic [RT_W-1:0]    len_reg  [QW+1];
    logic [2:0]         dneg_reg [QW+1];
    logic               dzero_reg [QW+1];

    comp_t              comp_reg [3];
    logic               zero_reg;

    logic [NW-1:0]      num [3];
    logic [REM_W-1:0]   st_t [SQ_STG+1];
    logic [REM_W-1:0]   st_trial [SQ_STG+1];
    logic [MAG_W+1:0]   dt [QW+1][3];

    // Rounded numerators: magnitude scaled by one, plus half the length.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            num[c] = NW'({smag_reg[SQ_STG][c], {FRAC_BITS{1'b0}}})
                   + NW'(root_reg[SQ_STG] >> 1);
        end
    end

    // One result bit per square root stage.
    always_comb
    begin
        st_t[0]     = '0;
        st_trial[0] = '0;
        for (int j = 1; j <= SQ_STG; j++)
        begin
            st_t[j]     = {srem_reg[j-1][REM_W-3:0], sn_reg[j-1][2*(SQ_STG-j)+:2]};
            st_trial[j] = REM_W'({root_reg[j-1], 2'b01});
        end
    end

    // One quotient bit per divider stage.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            dt[0][c] = '0;
        end
        for (int k = 1; k <= QW; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                dt[k][c] = {dr_reg[k-1][c], nlow_reg[k-1][c][QW-k]};
            end
        end
    end

    // Magnitudes, squares and their sum.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                mag1_reg[c] <= vec_in[c][SCL_W-1] ? MAG_W'(-vec_in[c]) : MAG_W'(vec_in[c]);
                neg1_reg[c] <= vec_in[c][SCL_W-1];
                sq_reg[c]   <= mag1_reg[c] * mag1_reg[c];
                mag2_reg[c] <= mag1_reg[c];
                neg2_reg[c] <= neg1_reg[c];
                smag_reg[0][c] <= mag2_reg[c];
            end
            zero2_reg <= (mag1_reg[0] == '0) && (mag1_reg[1] == '0) && (mag1_reg[2] == '0);
            sn_reg[0]    <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            srem_reg[0]  <= '0;
            root_reg[0]  <= '0;
            sneg_reg[0]  <= neg2_reg;
            szero_reg[0] <= zero2_reg;
        end
    end

    // Square root stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 1; j <= SQ_STG; j++)
            begin
                if (st_t[j] >= st_trial[j])
                begin
                    srem_reg[j] <= st_t[j] - st_trial[j];
                    root_reg[j] <= {root_reg[j-1][RT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_reg[j] <= st_t[j];
                    root_reg[j] <= {root_reg[j-1][RT_W-2:0], 1'b0};
                end
                sn_reg[j]    <= sn_reg[j-1];
                smag_reg[j]  <= smag_reg[j-1];
                sneg_reg[j]  <= sneg_reg[j-1];
                szero_reg[j] <= szero_reg[j-1];
            end
        end
    end

    // Numerator setup and divider stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                dr_reg[0][c]   <= {1'b0, num[c][NW-1:QW]};
                nlow_reg[0][c] <= num[c][QW-1:0];
                q_reg[0][c]    <= '0;
            end
            len_reg[0]   <= root_reg[SQ_STG];
            dneg_reg[0]  <= sneg_reg[SQ_STG];
            dzero_reg[0] <= szero_reg[SQ_STG];
            for (int k = 1; k <= QW; k++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (dt[k][c] >= {1'b0, len_reg[k-1]})
                    begin
                        dr_reg[k][c] <= (MAG_W+1)'(dt[k][c] - {1'b0, len_reg[k-1]});
                        q_reg[k][c]  <= {q_reg[k-1][c][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        dr_reg[k][c] <= dt[k][c][MAG_W:0];
                        q_reg[k][c]  <= {q_reg[k-1][c][QW-2:0], 1'b0};
                    end
                    nlow_reg[k][c] <= nlow_reg[k-1][c];
                end
                len_reg[k]   <= len_reg[k-1];
                dneg_reg[k]  <= dneg_reg[k-1];
                dzero_reg[k] <= dzero_reg[k-1];
            end
        end
    end

    // Sign and zero-length handling.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (dzero_reg[QW])
                begin
                    comp_reg[c] <= '0;
                end
                else if (dneg_reg[QW][c])
                begin
                    comp_reg[c] <= -$signed(32'(q_reg[QW][c]));
                end
                else
                begin
                    comp_reg[c] <= $signed(32'(q_reg[QW][c]));
                end
            end
            zero_reg <= dzero_reg[QW];
        end
    end

    assign comp = comp_reg;
    assign zero = zero_reg;

endmodule

// ===== design/look_at_camera_basis_unit.sv =====
// Channel  Direction  Payload
// s_axis   in         tdata: eye x,y,z, target x,y,z, up x,y,z (32 bits each)
// m_axis   out        tdata: comp x,y,z, comp w; tuser: row index, degenerate;
//                     tlast: last row
//
// The first row is offered once the pose has passed every stage and been loaded into the row holder.
// Once the pipeline is full, poses are taken at the pace of the output channel, which
// carries four rows per pose. Until then the pipeline takes a pose per cycle.
// Reset clears the stage valid bits and the row holder's valid flag and row counter.
// When the output holder is busy and the last stage is full, the whole
// pipeline freezes; nothing is dropped or repeated.
module look_at_camera_basis_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [287:0] s_axis_tdata,  // eye_x, eye_y, eye_z, target_x..z, up_x..z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,  // comp_x, comp_y, comp_z, comp_w, zero pad
    output logic [2:0]   m_axis_tuser,  // row_index, degenerate
    output logic         m_axis_tlast
);
    import lacb_pkg::*;

    localparam int UNIT_LAT = FRAC_BITS + 37;
    localparam int DEPTH    = 14 + UNIT_LAT;
    localparam logic [16:0] W_ONE = (FRAC_BITS <= 16) ? 17'(1 << FRAC_BITS) : 17'd0;

    logic              en;
    logic              load;
    logic [DEPTH-1:0]  v_reg;

    logic signed [32:0] at_reg [3];
    logic signed [31:0] up_reg [3];
    logic [95:0]        eye_reg [DEPTH];

    scl_t  up_s [3];
    scl_t  at_s [3];
    crs_t  right_raw [3];
    scl_t  right_s [3];
    crs_t  tup_raw [3];
    scl_t  tup_s [3];
    scl_t  at_d_reg [10][3];
    scl_t  rt_d_reg [5][3];

    comp_t rc [3];
    comp_t uc [3];
    comp_t fc [3];
    logic  rz;
    logic  uz;
    logic  fz;

    comp_t row_reg [3][3];
    logic [95:0] eye_hold_reg;
    logic  deg_reg;
    logic  hold_valid_reg;
    logic  hold_valid_next;
    row_t  row_cnt_reg;
    row_t  row_cnt_next;

    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [16:0] out_w;

    // Pipeline advance: the last stage moves only into a free or emptying row holder.
    assign load = v_reg[DEPTH-1]
                  && (!hold_valid_reg || (m_axis_tready && row_cnt_reg == ROW_EYE));
    assign en   = !v_reg[DEPTH-1] || load;
    assign s_axis_tready = en;

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[DEPTH-2:0], s_axis_tvalid};
        end
    end

    // Input stage: forward vector, up vector and the eye delay line.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                at_reg[i] <= $signed({s_axis_tdata[96+32*i+31], s_axis_tdata[96+32*i+:32]})
                           - $signed({s_axis_tdata[32*i+31], s_axis_tdata[32*i+:32]});
                up_reg[i] <= $signed(s_axis_tdata[192+32*i+:32]);
            end
            eye_reg[0] <= s_axis_tdata[95:0];
            for (int k = 1; k < DEPTH; k++)
            begin
                eye_reg[k] <= eye_reg[k-1];
            end
        end
    end

    lacb_blk #(.IN_W(32)) u_blk_up (.clk(clk), .en(en), .vec_in(up_reg), .vec_out(up_s));
    lacb_blk #(.IN_W(33)) u_blk_at (.clk(clk), .en(en), .vec_in(at_reg), .vec_out(at_s));

    // right = up x at
    lacb_cross u_cross_right (.clk(clk), .en(en), .a(up_s), .b(at_s), .prod(right_raw));

    lacb_blk #(.IN_W(CRS_W)) u_blk_right (
        .clk(clk), .en(en), .vec_in(right_raw), .vec_out(right_s));

    // Alignment delays for the scaled forward and right vectors.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            at_d_reg[0] <= at_s;
            for (int k = 1; k < 10; k++)
            begin
                at_d_reg[k] <= at_d_reg[k-1];
            end
            rt_d_reg[0] <= right_s;
            for (int k = 1; k < 5; k++)
            begin
                rt_d_reg[k] <= rt_d_reg[k-1];
            end
        end
    end

    // true_up = at x right
    lacb_cross u_cross_up (.clk(clk), .en(en), .a(at_d_reg[4]), .b(right_s), .prod(tup_raw));

    lacb_blk #(.IN_W(CRS_W)) u_blk_tup (
        .clk(clk), .en(en), .vec_in(tup_raw), .vec_out(tup_s));

    lacb_unit #(.FRAC_BITS(FRAC_BITS)) u_unit_right (
        .clk(clk), .en(en), .vec_in(rt_d_reg[4]), .comp(rc), .zero(rz));
    lacb_unit #(.FRAC_BITS(FRAC_BITS)) u_unit_up (
        .clk(clk), .en(en), .vec_in(tup_s), .comp(uc), .zero(uz));
    lacb_unit #(.FRAC_BITS(FRAC_BITS)) u_unit_fwd (
        .clk(clk), .en(en), .vec_in(at_d_reg[9]), .comp(fc), .zero(fz));

    // Row holder control.
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        row_cnt_next    = row_cnt_reg;
        if (load)
        begin
            hold_valid_next = 1'b1;
            row_cnt_next    = ROW_RIGHT;
        end
        else if (hold_valid_reg && m_axis_tready)
        begin
            if (row_cnt_reg == ROW_EYE)
            begin
                hold_valid_next = 1'b0;
            end
            else
            begin
                row_cnt_next = row_t'(row_cnt_reg + 2'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            row_cnt_reg    <= ROW_RIGHT;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            row_cnt_reg    <= row_cnt_next;
        end
    end

    // Row holder payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg[0]   <= rc;
            row_reg[1]   <= uc;
            row_reg[2]   <= fc;
            eye_hold_reg <= eye_reg[DEPTH-1];
            deg_reg      <= rz || uz || fz;
        end
    end

    // Row selection.
    always_comb
    begin
        unique case (row_cnt_reg)
            ROW_RIGHT:
            begin
                out_x = row_reg[0][0];
                out_y = row_reg[0][1];
                out_z = row_reg[0][2];
                out_w = '0;
            end
            ROW_UP:
            begin
                out_x = row_reg[1][0];
                out_y = row_reg[1][1];
                out_z = row_reg[1][2];
                out_w = '0;
            end
            ROW_FWD:
            begin
                out_x = row_reg[2][0];
                out_y = row_reg[2][1];
                out_z = row_reg[2][2];
                out_w = '0;
            end
            ROW_EYE:
            begin
                out_x = eye_hold_reg[31:0];
                out_y = eye_hold_reg[63:32];
                out_z = eye_hold_reg[95:64];
                out_w = W_ONE;
            end
        endcase
    end

    assign m_axis_tvalid = hold_valid_reg;
    assign m_axis_tdata  = {7'd0, out_w, out_z, out_y, out_x};
    assign m_axis_tuser  = {deg_reg, row_cnt_reg};
    assign m_axis_tlast  = (row_cnt_reg == ROW_EYE);

endmodule

// ===== design/lacb_checker.sv =====
module lacb_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [287:0] s_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [119:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser,
    input logic         m_axis_tlast
);
    import lacb_pkg::*;

    // The last flag marks exactly the eye row.
    a_last_is_eye: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[1:0] == ROW_EYE)))
        else $error("tlast does not match the eye row");

    // Rows of one matrix follow each other without gaps.
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && (m_axis_tuser[1:0] == $past(m_axis_tuser[1:0]) + 2'd1)))
        else $error("matrix rows out of order");

    // The degenerate flag holds for a whole matrix.
    a_deg_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tuser[2] == $past(m_axis_tuser[2])))
        else $error("degenerate flag changed within a matrix");

    // Direction rows carry w = 0.
    a_dir_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[112:96] == 17'd0))
        else $error("nonzero w on a direction row");

    // A stalled output row holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output request changed while stalled");

endmodule

bind look_at_camera_basis_unit lacb_checker u_lacb_checker (.*);
